>>> hw/rtl/audio_envelope_trigger_core_macros.svh
// ----------------------------------------------------------------------------
// audio_envelope_trigger_core_macros
// Assertion macros used by the checker file of the envelope trigger core.
// ----------------------------------------------------------------------------
`ifndef AUDIO_ENVELOPE_TRIGGER_CORE_MACROS_SVH
`define AUDIO_ENVELOPE_TRIGGER_CORE_MACROS_SVH

// Assertion that is checked outside reset only.
`define AET_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed in envelope trigger core");

// Assertion that is also checked during reset.
`define AET_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("reset assertion failed in envelope trigger core");

`endif

>>> hw/rtl/aet_pkg.sv
// ----------------------------------------------------------------------------
// aet_pkg
// Types, constants and register codes of the envelope trigger core.
// ----------------------------------------------------------------------------
package aet_pkg;

    localparam int CHANNELS_DEFAULT = 4;
    localparam int CFG_IDX_W        = 3;
    localparam int DIV_STEPS        = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK_GAIN   = 3'd0,
        CFG_RELEASE_GAIN  = 3'd1,
        CFG_CEILING_LEVEL = 3'd2,
        CFG_TRIG_ON_LEVEL = 3'd3,
        CFG_TRIG_OFF_LEVEL = 3'd4
    } cfg_reg_t;

    localparam logic [15:0] ATTACK_GAIN_RST  = 16'd64855;
    localparam logic [15:0] RELEASE_GAIN_RST = 16'd65522;
    localparam logic [15:0] LEVEL_RST        = 16'd328;

    typedef struct packed {
        logic [1:0]         chan;
        logic signed [15:0] sample;
        logic               block_last;
    } aet_in_t;

    typedef struct packed {
        logic [1:0]  out_chan;
        logic [15:0] envelope_level;
        logic        trigger_active;
        logic [15:0] peak_level;
        logic [15:0] limited_level;
        logic        block_done;
    } aet_out_t;

    typedef struct packed {
        logic [23:0] env;
        logic        trig;
        logic        on_seen;
        logic        off_seen;
        logic [15:0] peak;
        logic [15:0] limit;
        logic        fresh;
    } aet_entry_t;

    localparam int ENTRY_W = $bits(aet_entry_t);

    localparam aet_entry_t ENTRY_RST = '{
        env: 24'd0, trig: 1'b0, on_seen: 1'b0, off_seen: 1'b1,
        peak: 16'd0, limit: 16'd0, fresh: 1'b1
    };

endpackage

>>> hw/rtl/aet_ram.sv
// ----------------------------------------------------------------------------
// aet_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module aet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/audio_envelope_trigger_core.sv
// ----------------------------------------------------------------------------
// audio_envelope_trigger_core
// Per-channel attack/release envelope follower with block peak, limiter and
// trigger flag.
// ----------------------------------------------------------------------------
// One request is handled at a time. An in-range sample passes through the
// states READ, FOLLOW, ENV, DIV and DONE when the envelope is above the
// ceiling, since the limited level then needs a 16-step restoring divider,
// and skips DIV otherwise; one beyond CHANNELS goes from READ to DONE.
// The channel state lives in one RAM that is read when a request is taken
// and written back when its result is loaded into the output register.
// A finished result waits in that register while the next request is
// taken. Configuration writes are always accepted.
module audio_envelope_trigger_core #(
    parameter int CHANNELS = aet_pkg::CHANNELS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  aet_pkg::aet_in_t                   s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output aet_pkg::aet_out_t                  m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [aet_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [15:0]                        cfg_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_FOLLOW = 6'b000100,
        S_ENV    = 6'b001000,
        S_DIV    = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] attack_reg, release_reg, ceil_reg, on_lvl_reg, off_lvl_reg;

    aet_pkg::aet_in_t    in_reg;
    logic [CHANNELS-1:0] vld_reg;
    logic                hit_reg;
    aet_pkg::aet_entry_t entry_reg;
    aet_pkg::aet_entry_t rd_entry, base_entry, fin_entry;
    logic [aet_pkg::ENTRY_W-1:0] rd_data;

    logic [23:0] d_reg, env_reg, rem_reg;
    logic [15:0] gain_reg, mag_reg, nlo_reg, q_reg, lim_reg;
    logic [31:0] cm_reg;
    logic        att_reg;
    logic [3:0]  cnt_reg;

    logic              m_valid_reg;
    aet_pkg::aet_out_t m_data_reg;

    logic        in_range;
    logic        out_free;
    logic [15:0] mag_in;
    logic [23:0] magf_in, magf_reg;
    logic [39:0] follow_prod;
    logic [23:0] follow_part;
    logic [39:0] div_num;
    logic [24:0] div_trial;
    logic        div_bit;
    logic [AW-1:0] addr;

    assign in_range  = 32'(in_reg.chan) < 32'(CHANNELS);
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign addr      = AW'(in_reg.chan);

    aet_ram #(
        .WIDTH (aet_pkg::ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   ((state_reg == S_DONE) && out_free && in_range),
        .wr_addr (addr),
        .wr_data (fin_entry),
        .rd_addr (AW'(s_data.chan)),
        .rd_data (rd_data)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_reg  <= aet_pkg::ATTACK_GAIN_RST;
            release_reg <= aet_pkg::RELEASE_GAIN_RST;
            ceil_reg    <= aet_pkg::LEVEL_RST;
            on_lvl_reg  <= aet_pkg::LEVEL_RST;
            off_lvl_reg <= aet_pkg::LEVEL_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                aet_pkg::CFG_ATTACK_GAIN:    attack_reg  <= cfg_data;
                aet_pkg::CFG_RELEASE_GAIN:   release_reg <= cfg_data;
                aet_pkg::CFG_CEILING_LEVEL:  ceil_reg    <= cfg_data;
                aet_pkg::CFG_TRIG_ON_LEVEL:  on_lvl_reg  <= cfg_data;
                aet_pkg::CFG_TRIG_OFF_LEVEL: off_lvl_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // An entry never written since reset reads as the reset entry, and a
    // fresh block clears its per-block marks before the update.
    always_comb begin
        rd_entry   = hit_reg ? aet_pkg::aet_entry_t'(rd_data) : aet_pkg::ENTRY_RST;
        base_entry = rd_entry;
        if (rd_entry.fresh) begin
            base_entry.peak     = 16'd0;
            base_entry.limit    = 16'd0;
            base_entry.on_seen  = rd_entry.trig;
            base_entry.off_seen = !rd_entry.trig;
            base_entry.fresh    = 1'b0;
        end
    end

    assign mag_in      = in_reg.sample[15] ? 16'(-in_reg.sample) : 16'(in_reg.sample);
    assign magf_in     = {mag_in, 8'd0};
    assign magf_reg    = {mag_reg, 8'd0};
    assign follow_prod = 40'(gain_reg) * 40'(d_reg);
    assign follow_part = follow_prod[39:16];
    assign div_num     = {cm_reg, 8'd0};
    assign div_trial   = {rem_reg, nlo_reg[15]};
    assign div_bit     = div_trial >= {1'b0, env_reg};

    always_comb begin
        fin_entry       = entry_reg;
        fin_entry.env   = env_reg;
        if (mag_reg > entry_reg.peak) begin
            fin_entry.peak = mag_reg;
        end
        if (lim_reg > entry_reg.limit) begin
            fin_entry.limit = lim_reg;
        end
        if (!entry_reg.on_seen && env_reg > {on_lvl_reg, 8'd0}) begin
            fin_entry.on_seen = 1'b1;
            fin_entry.trig    = 1'b1;
        end
        if (!entry_reg.off_seen && env_reg < {off_lvl_reg, 8'd0}) begin
            fin_entry.off_seen = 1'b1;
            fin_entry.trig     = 1'b0;
        end
        fin_entry.fresh = in_reg.block_last;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_valid) state_next = S_READ;
            S_READ:   state_next = in_range ? S_FOLLOW : S_DONE;
            S_FOLLOW: state_next = S_ENV;
            S_ENV:    state_next = (env_reg > {ceil_reg, 8'd0}) ? S_DIV : S_DONE;
            S_DIV:    if (cnt_reg == 4'(aet_pkg::DIV_STEPS - 1)) state_next = S_DONE;
            S_DONE:   if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
                if (in_range) begin
                    vld_reg[addr] <= 1'b1;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                in_reg  <= s_data;
                hit_reg <= (32'(s_data.chan) < 32'(CHANNELS)) && vld_reg[AW'(s_data.chan)];
            end
            S_READ: begin
                entry_reg <= base_entry;
                mag_reg   <= mag_in;
                cm_reg    <= 32'(ceil_reg) * 32'(mag_in);
                att_reg   <= rd_entry.env < magf_in;
                if (rd_entry.env < magf_in) begin
                    d_reg    <= magf_in - rd_entry.env;
                    gain_reg <= attack_reg;
                end else begin
                    d_reg    <= rd_entry.env - magf_in;
                    gain_reg <= release_reg;
                end
            end
            S_FOLLOW: begin
                env_reg <= att_reg ? magf_reg - follow_part : magf_reg + follow_part;
            end
            S_ENV: begin
                rem_reg <= div_num[39:16];
                nlo_reg <= div_num[15:0];
                q_reg   <= '0;
                cnt_reg <= '0;
                lim_reg <= mag_reg;
            end
            S_DIV: begin
                rem_reg <= div_bit ? 24'(div_trial - {1'b0, env_reg}) : div_trial[23:0];
                nlo_reg <= {nlo_reg[14:0], 1'b0};
                q_reg   <= {q_reg[14:0], div_bit};
                cnt_reg <= cnt_reg + 4'd1;
                lim_reg <= {q_reg[14:0], div_bit};
            end
            S_DONE: begin
                if (out_free) begin
                    m_data_reg.out_chan   <= in_reg.chan;
                    m_data_reg.block_done <= in_reg.block_last;
                    if (in_range) begin
                        m_data_reg.envelope_level <= env_reg[23:8];
                        m_data_reg.trigger_active <= fin_entry.trig;
                        m_data_reg.peak_level     <= fin_entry.peak;
                        m_data_reg.limited_level  <= fin_entry.limit;
                    end else begin
                        m_data_reg.envelope_level <= '0;
                        m_data_reg.trigger_active <= 1'b0;
                        m_data_reg.peak_level     <= '0;
                        m_data_reg.limited_level  <= '0;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

>>> hw/rtl/aet_checker.sv
// ----------------------------------------------------------------------------
// aet_checker
// Port-level checks of the envelope trigger core, bound to the top level.
// ----------------------------------------------------------------------------
`include "audio_envelope_trigger_core_macros.svh"

module aet_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input aet_pkg::aet_out_t m_data
);

    // A stalled result keeps its valid and its payload.
    `AET_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data))

    // The limited level never exceeds the block peak.
    `AET_ASSERT(a_lim_le_peak, m_valid |-> m_data.limited_level <= m_data.peak_level)

    // A zero peak level in a result means a zero limited level too.
    `AET_ASSERT(a_zero_peak, m_valid && m_data.peak_level == 16'd0
                |-> m_data.limited_level == 16'd0)

    // No result is offered in the cycle after a reset cycle.
    `AET_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_valid)

endmodule

bind audio_envelope_trigger_core aet_checker u_aet_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
